FILE: hw/rtl/bot_pkg.sv
// ----------------------------------------------------------------------------
// bot_pkg
// Shared constants, types and lane helpers for the box overlap tester.
// ----------------------------------------------------------------------------
package bot_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int LANE_BITS   = 16;
	localparam int CW          = (COORD_WIDTH < LANE_BITS) ? COORD_WIDTH : LANE_BITS;
	localparam int WORD_BITS   = 3 * LANE_BITS;
	localparam int NUM_REGS    = 7;
	localparam int IDX_BITS    = 3;
	localparam int IN_BITS     = NUM_REGS * WORD_BITS;
	localparam int OUT_BITS    = 8;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [IDX_BITS-1:0]  reg_idx_t;

	localparam reg_idx_t REG_CENTER   = 3'd0;
	localparam reg_idx_t REG_AXIS_X   = 3'd1;
	localparam reg_idx_t REG_AXIS_Y   = 3'd2;
	localparam reg_idx_t REG_AXIS_Z   = 3'd3;
	localparam reg_idx_t REG_HALF_LEN = 3'd4;
	localparam reg_idx_t REG_MIN      = 3'd5;
	localparam reg_idx_t REG_MAX      = 3'd6;

	localparam word_t RST_CENTER   = 48'd0;
	localparam word_t RST_AXIS_X   = 48'd16384;
	localparam word_t RST_AXIS_Y   = 48'd1073741824;
	localparam word_t RST_AXIS_Z   = 48'd70368744177664;
	localparam word_t RST_HALF_LEN = 48'd1099528405248;
	localparam word_t RST_MIN      = 48'd280379743338240;
	localparam word_t RST_MAX      = 48'd1099528405248;

	// |cos| > 0.999999 in Q2.28
	localparam logic [32:0] PAR_CUTOFF = 33'd268435187;

	function automatic logic signed [LANE_BITS-1:0] pos_lane(word_t w, int k);
		logic signed [CW-1:0] v;
		v = $signed(w[LANE_BITS*k +: CW]);
		return LANE_BITS'(v);
	endfunction

	function automatic logic [LANE_BITS-1:0] half_lane(word_t w, int k);
		return LANE_BITS'(w[LANE_BITS*k +: CW]);
	endfunction

	function automatic logic signed [LANE_BITS-1:0] axis_lane(word_t w, int k);
		return $signed(w[LANE_BITS*k +: LANE_BITS]);
	endfunction

endpackage

FILE: hw/rtl/box_overlap_test.sv
// ----------------------------------------------------------------------------
// box_overlap_test
// Streams target boxes against a configured reference box; returns an
// axis-aligned overlap flag and a fifteen-axis oriented-box overlap flag.
// ----------------------------------------------------------------------------
// Each input transaction passes through stage registers s1 to s5 to reach the output port.
// Throughput: one transaction per cycle; the five-stage pipeline stalls as one
// when the output is held, so s_axis_tready follows the output register.
// Reset: pipeline valid bits clear; reference registers take their defaults
// (unit box at the origin with identity axes).
module box_overlap_test import bot_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  reg_idx_t            cfg_addr,
	input  word_t               cfg_data,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// tgt_center, tgt_axis_x, tgt_axis_y, tgt_axis_z, tgt_half_len, tgt_min, tgt_max
	input  logic [IN_BITS-1:0]  s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// aabb_hit, obb_hit, zero fill
	output logic [OUT_BITS-1:0] m_axis_tdata
);

	word_t cfg_q [NUM_REGS];

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [16:0] diff_s1 [3];
	logic signed [15:0] ta_s1   [3][3];
	logic        [15:0] th_s1   [3];
	logic               aabb_s1;

	logic signed [33:0] d_s2  [3];
	logic signed [33:0] e_s2  [3];
	logic signed [32:0] c_s2  [3][3];
	logic        [15:0] th_s2 [3];
	logic               aabb_s2;

	logic        [48:0] pr_s3   [3][3][3];
	logic        [48:0] pt_s3   [3][3][3];
	logic signed [66:0] xa_s3   [3][3];
	logic signed [66:0] xb_s3   [3][3];
	logic        [33:0] dm_s3   [3];
	logic        [33:0] em_s3   [3];
	logic        [15:0] th_s3   [3];
	logic               par_s3;
	logic               aabb_s3;

	logic        [67:0] xl_s4 [3][3];
	logic        [50:0] xr_s4 [3][3];
	logic               fsep_s4;
	logic               par_s4;
	logic               aabb_s4;

	logic aabb_s5, obb_s5;

	assign adv           = !v_s5 || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = {6'b0, obb_s5, aabb_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_CENTER]   <= RST_CENTER;
			cfg_q[REG_AXIS_X]   <= RST_AXIS_X;
			cfg_q[REG_AXIS_Y]   <= RST_AXIS_Y;
			cfg_q[REG_AXIS_Z]   <= RST_AXIS_Z;
			cfg_q[REG_HALF_LEN] <= RST_HALF_LEN;
			cfg_q[REG_MIN]      <= RST_MIN;
			cfg_q[REG_MAX]      <= RST_MAX;
		end else if (cfg_valid && cfg_addr < NUM_REGS) begin
			cfg_q[cfg_addr] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: unpack, centre difference, AABB compare
	logic aabb_n;

	always_comb begin
		aabb_n = 1'b1;
		for (int k = 0; k < 3; k++) begin
			if (pos_lane(cfg_q[REG_MIN], k) >
			    pos_lane(s_axis_tdata[6*WORD_BITS +: WORD_BITS], k))
				aabb_n = 1'b0;
			if (pos_lane(cfg_q[REG_MAX], k) <
			    pos_lane(s_axis_tdata[5*WORD_BITS +: WORD_BITS], k))
				aabb_n = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			aabb_s1 <= aabb_n;
			for (int k = 0; k < 3; k++) begin
				diff_s1[k] <= 17'(pos_lane(cfg_q[REG_CENTER], k))
					- 17'(pos_lane(s_axis_tdata[0 +: WORD_BITS], k));
				th_s1[k] <= half_lane(s_axis_tdata[4*WORD_BITS +: WORD_BITS], k);
				for (int i = 0; i < 3; i++)
					ta_s1[i][k] <= axis_lane(s_axis_tdata[(1+i)*WORD_BITS +: WORD_BITS], k);
			end
		end
	end

	// stage 2: projections and cosines
	always_ff @(posedge clk) begin
		if (adv) begin
			aabb_s2 <= aabb_s1;
			th_s2   <= th_s1;
			for (int i = 0; i < 3; i++) begin
				d_s2[i] <= diff_s1[0] * axis_lane(cfg_q[1+i], 0)
					+ diff_s1[1] * axis_lane(cfg_q[1+i], 1)
					+ diff_s1[2] * axis_lane(cfg_q[1+i], 2);
				e_s2[i] <= diff_s1[0] * ta_s1[i][0] + diff_s1[1] * ta_s1[i][1]
					+ diff_s1[2] * ta_s1[i][2];
				for (int j = 0; j < 3; j++)
					c_s2[i][j] <= axis_lane(cfg_q[1+i], 0) * ta_s1[j][0]
						+ axis_lane(cfg_q[1+i], 1) * ta_s1[j][1]
						+ axis_lane(cfg_q[1+i], 2) * ta_s1[j][2];
			end
		end
	end

	// stage 3: radius products and cross-axis distance products
	logic [32:0] ac [3][3];
	logic        par_n;

	always_comb begin
		par_n = 1'b0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				ac[i][j] = c_s2[i][j][32] ? 33'(-c_s2[i][j]) : 33'(c_s2[i][j]);
				if (ac[i][j] > PAR_CUTOFF)
					par_n = 1'b1;
			end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			aabb_s3 <= aabb_s2;
			par_s3  <= par_n;
			th_s3   <= th_s2;
			for (int i = 0; i < 3; i++) begin
				dm_s3[i] <= d_s2[i][33] ? 34'(-d_s2[i]) : 34'(d_s2[i]);
				em_s3[i] <= e_s2[i][33] ? 34'(-e_s2[i]) : 34'(e_s2[i]);
				for (int a = 0; a < 3; a++)
					for (int j = 0; j < 3; j++) begin
						pr_s3[a][i][j] <= half_lane(cfg_q[REG_HALF_LEN], a) * ac[i][j];
						pt_s3[a][i][j] <= th_s2[a] * ac[i][j];
					end
				for (int j = 0; j < 3; j++) begin
					xa_s3[i][j] <= d_s2[(i == 0) ? 2 : i-1] * c_s2[(i == 2) ? 0 : i+1][j];
					xb_s3[i][j] <= d_s2[(i == 2) ? 0 : i+1] * c_s2[(i == 0) ? 2 : i-1][j];
				end
			end
		end
	end

	// stage 4: face axis tests, cross-axis sums
	logic [55:0] flhs [3];
	logic [55:0] frhs [3];
	logic [55:0] glhs [3];
	logic [55:0] grhs [3];
	logic        fsep_n;

	always_comb begin
		fsep_n = 1'b0;
		for (int i = 0; i < 3; i++) begin
			flhs[i] = {8'b0, dm_s3[i], 14'b0};
			frhs[i] = 56'({half_lane(cfg_q[REG_HALF_LEN], i), 28'b0})
				+ 56'(pt_s3[0][i][0]) + 56'(pt_s3[1][i][1]) + 56'(pt_s3[2][i][2]);
			glhs[i] = {8'b0, em_s3[i], 14'b0};
			grhs[i] = 56'({th_s3[i], 28'b0})
				+ 56'(pr_s3[0][0][i]) + 56'(pr_s3[1][1][i]) + 56'(pr_s3[2][2][i]);
			if (flhs[i] > frhs[i] || glhs[i] > grhs[i])
				fsep_n = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			aabb_s4 <= aabb_s3;
			par_s4  <= par_s3;
			fsep_s4 <= fsep_n;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					xl_s4[i][j] <= (xa_s3[i][j] >= xb_s3[i][j])
						? 68'(68'(xa_s3[i][j]) - 68'(xb_s3[i][j]))
						: 68'(68'(xb_s3[i][j]) - 68'(xa_s3[i][j]));
					xr_s4[i][j] <= 51'(pr_s3[(i == 2) ? 0 : i+1][(i == 0) ? 2 : i-1][j])
						+ 51'(pr_s3[(i == 0) ? 2 : i-1][(i == 2) ? 0 : i+1][j])
						+ 51'(pt_s3[(j == 2) ? 0 : j+1][i][(j == 0) ? 2 : j-1])
						+ 51'(pt_s3[(j == 0) ? 2 : j-1][i][(j == 2) ? 0 : j+1]);
				end
		end
	end

	// stage 5: cross-axis compares, result register
	logic xsep_n;

	always_comb begin
		xsep_n = 1'b0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if (xl_s4[i][j] > {3'b0, xr_s4[i][j], 14'b0})
					xsep_n = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			aabb_s5 <= aabb_s4;
			obb_s5  <= !fsep_s4 && (par_s4 || !xsep_n);
		end
	end

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> v_s1)
		else $error("accepted transaction did not enter stage 1");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while output stalled");

	a_face_sep: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s4 && fsep_s4) |=> (m_axis_tvalid && !m_axis_tdata[1]))
		else $error("face separation not reported as miss");

	a_parallel: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s4 && par_s4 && !fsep_s4) |=> m_axis_tdata[1])
		else $error("parallel pair without face separation not a hit");

endmodule

FILE: tb/box_overlap_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_overlap_test_tb
// Streams target boxes through the overlap tester and checks both flags
// against an exact integer model of the axis-aligned and separating-axis tests.
// ----------------------------------------------------------------------------
module box_overlap_test_tb import bot_pkg::*; ();

	class hit_scoreboard;
		logic [1:0] pending[$];
		int errors;
		int checked;

		function void note(logic [1:0] flags);
			pending.push_back(flags);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check(logic [OUT_BITS-1:0] data);
			logic [1:0] want;
			checked++;
			if (pending.size() == 0) begin
				report("result with nothing expected");
				return;
			end
			want = pending.pop_front();
			if (data[0] !== want[0])
				report($sformatf("aabb_hit got %b want %b (result %0d)", data[0], want[0],
					checked));
			if (data[1] !== want[1])
				report($sformatf("obb_hit got %b want %b (result %0d)", data[1], want[1],
					checked));
			if (data[OUT_BITS-1:2] !== '0)
				report($sformatf("fill bits nonzero (result %0d)", checked));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	reg_idx_t            cfg_addr;
	word_t               cfg_data;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_BITS-1:0]  s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_BITS-1:0] m_axis_tdata;

	word_t ref_box[NUM_REGS];
	hit_scoreboard sb;
	int src_idle_pct;
	int snk_idle_pct;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_cnt = 0;
	int sent;

	box_overlap_test dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	function automatic longint sx(logic [15:0] v, int w);
		longint r;
		r = v & ((64'd1 << w) - 1);
		if (r[w-1])
			r = r - (longint'(1) << w);
		return r;
	endfunction

	function automatic longint posv(word_t w, int k);
		return sx(w[16*k +: 16], CW);
	endfunction

	function automatic longint halfv(word_t w, int k);
		return w[16*k +: 16] & ((64'd1 << CW) - 1);
	endfunction

	function automatic longint axv(word_t w, int k);
		return sx(w[16*k +: 16], 16);
	endfunction

	function automatic logic [1:0] predict_hits(logic [IN_BITS-1:0] box);
		word_t t[NUM_REGS];
		longint ra[3][3], ta[3][3], df[3], c[3][3], ac[3][3], d[3], e[3], rh[3], th[3];
		logic signed [127:0] lhs, rhs;
		logic aabb, obb, par;
		int i, j, k, i0, i1, j0, j1;
		for (i = 0; i < NUM_REGS; i++)
			t[i] = box[WORD_BITS*i +: WORD_BITS];
		aabb = 1'b1;
		for (k = 0; k < 3; k++) begin
			if (posv(ref_box[REG_MIN], k) > posv(t[6], k)) aabb = 1'b0;
			if (posv(ref_box[REG_MAX], k) < posv(t[5], k)) aabb = 1'b0;
		end
		par = 1'b0;
		for (k = 0; k < 3; k++) begin
			df[k] = posv(ref_box[REG_CENTER], k) - posv(t[0], k);
			rh[k] = halfv(ref_box[REG_HALF_LEN], k);
			th[k] = halfv(t[4], k);
			for (i = 0; i < 3; i++) begin
				ra[i][k] = axv(ref_box[REG_AXIS_X + i], k);
				ta[i][k] = axv(t[1 + i], k);
			end
		end
		for (i = 0; i < 3; i++) begin
			d[i] = 0;
			e[i] = 0;
			for (k = 0; k < 3; k++) begin
				d[i] += df[k] * ra[i][k];
				e[i] += df[k] * ta[i][k];
			end
			for (j = 0; j < 3; j++) begin
				c[i][j] = 0;
				for (k = 0; k < 3; k++)
					c[i][j] += ra[i][k] * ta[j][k];
				ac[i][j] = c[i][j] < 0 ? -c[i][j] : c[i][j];
				if (ac[i][j] > longint'(PAR_CUTOFF)) par = 1'b1;
			end
		end
		obb = 1'b1;
		for (i = 0; i < 3; i++) begin
			lhs = 128'(d[i] < 0 ? -d[i] : d[i]) <<< 14;
			rhs = 128'(rh[i]) <<< 28;
			for (j = 0; j < 3; j++) rhs += 128'(th[j]) * 128'(ac[i][j]);
			if (lhs > rhs) obb = 1'b0;
		end
		for (j = 0; j < 3; j++) begin
			lhs = 128'(e[j] < 0 ? -e[j] : e[j]) <<< 14;
			rhs = 128'(th[j]) <<< 28;
			for (i = 0; i < 3; i++) rhs += 128'(rh[i]) * 128'(ac[i][j]);
			if (lhs > rhs) obb = 1'b0;
		end
		if (obb && !par) begin
			for (i = 0; i < 3; i++) begin
				i0 = (i + 1) % 3;
				i1 = (i + 2) % 3;
				for (j = 0; j < 3; j++) begin
					j0 = (j + 1) % 3;
					j1 = (j + 2) % 3;
					lhs = 128'(signed'(d[i1])) * 128'(signed'(c[i0][j]))
						- 128'(signed'(d[i0])) * 128'(signed'(c[i1][j]));
					if (lhs < 0) lhs = -lhs;
					rhs = (128'(rh[i0]) * 128'(ac[i1][j])
						+ 128'(rh[i1]) * 128'(ac[i0][j])
						+ 128'(th[j0]) * 128'(ac[i][j1])
						+ 128'(th[j1]) * 128'(ac[i][j0])) <<< 14;
					if (lhs > rhs) obb = 1'b0;
				end
			end
		end
		return {obb, aabb};
	endfunction

	task automatic write_reg(reg_idx_t idx, word_t val);
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx < NUM_REGS)
			ref_box[idx] = val;
		@(posedge clk);
	endtask

	task automatic send_box(logic [IN_BITS-1:0] box);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= box;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note(predict_hits(box));
		sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_lane(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(2048)) - 16'd1024;
			default: return 16'($urandom_range(1536));
		endcase
	endfunction

	function automatic word_t rand_word(int mode);
		return {rand_lane(mode), rand_lane(mode), rand_lane(mode)};
	endfunction

	function automatic word_t rand_axis();
		int m;
		word_t w;
		m = $urandom_range(3);
		if (m == 0) return rand_word(0);
		w = {rand_lane(1), rand_lane(1), rand_lane(1)};
		if (m == 1) w[16*$urandom_range(2) +: 16] = $urandom_range(1) ? 16'h4000 : 16'hC000;
		if (m == 2) w[16*$urandom_range(2) +: 16] = 16'h3FF0 + 16'($urandom_range(15));
		return w;
	endfunction

	function automatic logic [IN_BITS-1:0] rand_box();
		logic [IN_BITS-1:0] b;
		int m;
		m = ($urandom_range(9) == 0) ? 0 : 1;
		b[0 +: 48]   = rand_word(m);
		b[48 +: 48]  = rand_axis();
		b[96 +: 48]  = rand_axis();
		b[144 +: 48] = rand_axis();
		b[192 +: 48] = m ? rand_word(2) : rand_word(0);
		b[240 +: 48] = rand_word(m);
		b[288 +: 48] = rand_word(m);
		return b;
	endfunction

	function automatic logic [IN_BITS-1:0] make_box(word_t cen, word_t ax, word_t ay,
			word_t az, word_t hl, word_t mn, word_t mx);
		return {mx, mn, hl, az, ay, ax, cen};
	endfunction

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check(m_axis_tdata);
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_cnt <= 60;
			hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin
		word_t one3, mone3, ident_x, ident_y, ident_z;
		int phase, n;
		sb = new();
		sent = 0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_addr = REG_CENTER;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		ref_box[REG_CENTER]   = RST_CENTER;
		ref_box[REG_AXIS_X]   = RST_AXIS_X;
		ref_box[REG_AXIS_Y]   = RST_AXIS_Y;
		ref_box[REG_AXIS_Z]   = RST_AXIS_Z;
		ref_box[REG_HALF_LEN] = RST_HALF_LEN;
		ref_box[REG_MIN]      = RST_MIN;
		ref_box[REG_MAX]      = RST_MAX;
		one3 = RST_MAX;
		mone3 = RST_MIN;
		ident_x = RST_AXIS_X;
		ident_y = RST_AXIS_Y;
		ident_z = RST_AXIS_Z;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset reference box
		send_box(make_box('0, ident_x, ident_y, ident_z, one3, mone3, one3));
		send_box(make_box({3{16'h0200}}, ident_x, ident_y, ident_z, one3, one3, one3));
		send_box(make_box({3{16'h0201}}, ident_x, ident_y, ident_z, one3,
			{3{16'h0101}}, {3{16'h0200}}));
		send_box(make_box({3{16'h7FFF}}, {3{16'hFFFF}}, {3{16'h8000}}, {3{16'h7FFF}},
			{3{16'hFFFF}}, {3{16'h7FFF}}, {3{16'h8000}}));
		send_box(make_box({3{16'h8000}}, '0, '0, '0, '0, {3{16'h8000}}, {3{16'h7FFF}}));
		send_box(make_box('0, {3{16'h2000}}, {16'h0, 16'h2D41, 16'hD2BF}, ident_x,
			{3{16'h0080}}, one3, mone3));
		send_box(make_box({16'h0, 16'h0, 16'h0300}, {16'h0, 16'h2D41, 16'h2D41},
			{16'h0, 16'h2D41, 16'hD2BF}, ident_z, {3{16'h0100}}, '0, '0));
		send_box(make_box({16'h0280, 16'h0280, 16'h0}, {16'h0, 16'h0B50, 16'h3E9C},
			{16'h3FFF, 16'h0, 16'h0}, {16'h0, 16'h3E9C, 16'hF4B0}, {3{16'h0100}},
			{3{16'hAAAA}}, {3{16'h5555}}));
		send_box(make_box({16'h0100, 16'h0150, 16'h0150}, {16'h0, 16'h2D41, 16'h2D41},
			{16'h2D41, 16'h0, 16'hD2BF}, {16'hD2BF, 16'h2D41, 16'h0}, {3{16'h0090}},
			{3{16'hFFFF}}, 48'h0));
		drain();

		// every register written, extreme and random settings
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 17;
					snk_idle_pct = 85;
				end
				2: begin
					src_idle_pct = 85;
					snk_idle_pct = 17;
				end
				4: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
				default: ;
			endcase
			if (phase == 1) begin
				write_reg(REG_CENTER, {3{16'h8000}});
				write_reg(REG_AXIS_X, {3{16'h7FFF}});
				write_reg(REG_AXIS_Y, {3{16'h8000}});
				write_reg(REG_AXIS_Z, {3{16'hFFFF}});
				write_reg(REG_HALF_LEN, {3{16'hFFFF}});
				write_reg(REG_MIN, {3{16'h7FFF}});
				write_reg(REG_MAX, {3{16'h8000}});
				write_reg(reg_idx_t'(7), '1);
			end else if (phase == 5) begin
				write_reg(REG_CENTER, '0);
				write_reg(REG_AXIS_X, ident_x);
				write_reg(REG_AXIS_Y, ident_y);
				write_reg(REG_AXIS_Z, ident_z);
				write_reg(REG_HALF_LEN, {3{16'h0300}});
				write_reg(REG_MIN, {3{16'hFD00}});
				write_reg(REG_MAX, {3{16'h0300}});
			end else begin
				write_reg(REG_CENTER, rand_word(1));
				write_reg(REG_AXIS_X, rand_axis());
				write_reg(REG_AXIS_Y, rand_axis());
				write_reg(REG_AXIS_Z, rand_axis());
				write_reg(REG_HALF_LEN, rand_word(2));
				write_reg(REG_MIN, rand_word(1));
				write_reg(REG_MAX, rand_word(1));
			end
			for (n = 0; n < 133; n++) begin
				if (phase == 4 && n == 20)
					hold_req = 1'b1;
				if (phase == 3 && n == 66)
					drain();
				send_box(rand_box());
			end
			drain();
		end

		repeat (10) @(posedge clk);
		$display("covered %0d target boxes, %0d results over seven reference settings",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
